@@ design/dera_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring allocator package
// Shared constants and types of the ring allocator.
// ----------------------------------------------------------------------------
package dera_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned ADDR_W_DEF = 32;
  localparam int unsigned LOG2_W     = 6;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 6'd20;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_POP,
    S_FIX,
    S_OUT
  } fsm_t;

endpackage

@@ design/dera_ram.sv @@
// ----------------------------------------------------------------------------
// Ring allocator RAM
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dera_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/double_ended_ring_allocator.sv @@
// ----------------------------------------------------------------------------
// Double-ended ring allocator
// Hands out aligned byte ranges of a power-of-two arena kept as a ring.
// ----------------------------------------------------------------------------
// The s_axis channel carries one command item: allocate, or free a slot.
// Every item gives exactly one result item on m_axis: status, slot, offset.
// Items are handled one at a time. An allocate, a rejected free, a free of
// the only live fragment or of a middle one goes from S_IDLE through S_READ
// to S_OUT, where its result is loaded into the output register; the next
// item is accepted once the state is back in S_IDLE. Freeing the first or
// last of several live fragments walks the deque in S_POP, popping each
// dead slot until the live neighbour is found; its entry, read from the
// fragment table, then sets the free boundary in S_FIX before S_OUT.
// The result waits in an output register while m_axis_tready is low. One
// further item is accepted and processed meanwhile, and its result waits
// until the register has been emptied.
// Write the arena_log2 register via cfg_we/cfg_wdata only while no item
// is in flight; the block does not enforce this. A write also empties the
// arena. Reset sets it to 20 and clears the arena and all live bits at once.
// ----------------------------------------------------------------------------
module double_ended_ring_allocator #(
  parameter int unsigned SLOTS  = dera_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_W = dera_pkg::ADDR_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[0], alloc_size[32:1], align_log2[37:33], handle[41:38], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot[5:2], offset[37:6], zero fill
  output logic [39:0] m_axis_tdata
);
  import dera_pkg::*;

  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned CAP = (ADDR_W < 32) ? ADDR_W : 32;

  fsm_t state, state_next;
  logic [LOG2_W-1:0] arena_log2;
  logic [63:0] free_begin, free_end;
  logic [SLOTS-1:0] live;
  logic [SW-1:0] head_slot, tail_slot;
  logic [CW-1:0] used_slots, live_count;

  cmd_t        cmd;
  logic [31:0] req;
  logic [4:0]  alog;
  logic [3:0]  hnd;
  status_t     res_status;
  logic [3:0]  res_slot;
  logic [31:0] res_offset;
  status_t     out_status;
  logic [3:0]  out_slot;
  logic [31:0] out_offset;
  logic        out_valid;
  logic        pop_head;

  logic [5:0]  l;
  logic [63:0] size_s, mask, am, ab, ae, alb, ale, frag_end;
  logic        same, fit_front, fit_back, alloc_ok, hnd_ok, pop_live;
  logic [SW-1:0] hnd_idx, rd_idx, wr_idx;

  logic        ram_we;
  logic [31:0] off_rd, len_rd, off_wd;

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
    return (32'(i) + 32'd1 >= SLOTS) ? '0 : SW'(32'(i) + 32'd1);
  endfunction
  function automatic logic [SW-1:0] prv(input logic [SW-1:0] i);
    return (i == '0) ? SW'(SLOTS - 1) : SW'(32'(i) - 32'd1);
  endfunction
  function automatic logic [5:0] eff_log2(input logic [5:0] v);
    if (v < 6'd4) return 6'd4;
    if (32'(v) > CAP) return 6'(CAP);
    return v;
  endfunction

  always_comb begin
    l      = eff_log2(arena_log2);
    size_s = 64'd1 << l;
    mask   = size_s - 64'd1;
    am     = (64'd1 << alog) - 64'd1;
    ab     = free_begin & mask;
    ae     = free_end & mask;
    alb    = (ab + am) & ~am;
    ale    = ae & ~am;
    same   = (free_begin >> l) == (free_end >> l);
    fit_front = 1'b0;
    fit_back  = 1'b0;
    if (same) begin
      fit_front = (alb + 64'(req) <= ae);
    end else if (alb + 64'(req) <= size_s) begin
      fit_front = 1'b1;
    end else if (64'(req) <= ale) begin
      fit_back = 1'b1;
    end
    alloc_ok = (32'(used_slots) < SLOTS) && (req != '0) && (fit_front || fit_back);
    hnd_idx  = SW'(hnd);
    hnd_ok   = (32'(hnd) < SLOTS) && live[hnd_idx];
    pop_live = pop_head ? live[head_slot] : live[prv(tail_slot)];
    rd_idx   = pop_head ? head_slot : prv(tail_slot);
    ram_we   = (state == S_READ) && (cmd == CMD_ALLOC) && alloc_ok;
    wr_idx   = fit_front ? tail_slot : prv(head_slot);
    off_wd   = fit_front ? alb[31:0] : ale[31:0] - req;
    frag_end = {32'd0, off_rd} + {32'd0, len_rd};
  end

  dera_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_off (
    .clk(clk), .we(ram_we), .waddr(wr_idx), .wdata(off_wd),
    .raddr(rd_idx), .rdata(off_rd)
  );
  dera_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_len (
    .clk(clk), .we(ram_we), .waddr(wr_idx), .wdata(req),
    .raddr(rd_idx), .rdata(len_rd)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_offset, out_slot, out_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_READ;
      S_READ: begin
        if (cmd == CMD_FREE && hnd_ok && live_count > CW'(1) &&
            (hnd_idx == head_slot || hnd_idx == prv(tail_slot))) begin
          state_next = S_POP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_POP:   if (pop_live) state_next = S_FIX;
      S_FIX:   state_next = S_OUT;
      S_OUT:   if (!out_valid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_log2 <= LOG2_RESET;
      free_begin <= '0;
      free_end   <= 64'd1 << eff_log2(LOG2_RESET);
      live <= '0; head_slot <= '0; tail_slot <= '0;
      used_slots <= '0; live_count <= '0;
      out_valid <= 1'b0;
      pop_head <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (cfg_we) begin
        arena_log2 <= cfg_wdata;
        free_begin <= '0;
        free_end   <= 64'd1 << eff_log2(cfg_wdata);
        live <= '0; head_slot <= '0; tail_slot <= '0;
        used_slots <= '0; live_count <= '0;
      end else begin
        unique case (state)
          S_IDLE: if (s_axis_tvalid) begin
            cmd  <= cmd_t'(s_axis_tdata[0]);
            req  <= s_axis_tdata[32:1];
            alog <= s_axis_tdata[37:33];
            hnd  <= s_axis_tdata[41:38];
            res_status <= ST_DONE; res_slot <= '0; res_offset <= '0;
          end
          S_READ: begin
            if (cmd == CMD_ALLOC) begin
              if (32'(used_slots) >= SLOTS) begin
                res_status <= ST_FULL;
              end else if (req == '0) begin
                res_status <= ST_NO_SPACE;
              end else if (fit_front) begin
                free_begin <= free_begin + (alb - ab) + 64'(req);
                res_offset <= alb[31:0];
                res_slot <= 4'(tail_slot);
                live[tail_slot] <= 1'b1;
                tail_slot <= nxt(tail_slot);
                used_slots <= used_slots + CW'(1); live_count <= live_count + CW'(1);
              end else if (fit_back) begin
                free_end <= free_end - (ae - ale) - 64'(req);
                res_offset <= ale[31:0] - req;
                res_slot <= 4'(prv(head_slot));
                live[prv(head_slot)] <= 1'b1;
                head_slot <= prv(head_slot);
                used_slots <= used_slots + CW'(1); live_count <= live_count + CW'(1);
              end else begin
                res_status <= ST_NO_SPACE;
              end
            end else begin
              pop_head <= (hnd_idx == head_slot);
              if (!hnd_ok) begin
                res_status <= ST_BAD;
              end else if (live_count <= CW'(1)) begin
                free_begin <= '0; free_end <= size_s;
                live <= '0; head_slot <= '0; tail_slot <= '0;
                used_slots <= '0; live_count <= '0;
              end else begin
                live[hnd_idx] <= 1'b0;
                live_count <= live_count - CW'(1);
              end
            end
          end
          S_POP: begin
            if (pop_head) begin
              if (!live[head_slot]) begin
                head_slot <= nxt(head_slot);
                used_slots <= used_slots - CW'(1);
              end
            end else if (!live[prv(tail_slot)]) begin
              tail_slot <= prv(tail_slot);
              used_slots <= used_slots - CW'(1);
            end
          end
          S_FIX: begin
            if (pop_head) begin
              free_end <= free_end + (({32'd0, off_rd} - free_end) & mask);
            end else begin
              free_begin <= free_begin - ((free_begin - frag_end) & mask);
            end
          end
          S_OUT: if (!out_valid || m_axis_tready) begin
            out_status <= res_status;
            out_slot   <= res_slot;
            out_offset <= res_offset;
            out_valid  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_slots) <= SLOTS);
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= used_slots);
`endif

endmodule

@@ tb/double_ended_ring_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended ring allocator testbench
// Sends allocate and free command items while both stream sides idle at
// random. Every result item is checked against a behavioural predictor of the
// arena boundaries and the slot deque.
// ----------------------------------------------------------------------------
module double_ended_ring_allocator_tb;
  import dera_pkg::*;

  localparam int NSLOT = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  double_ended_ring_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] offset;
  } outcome_t;

  // Predictor state.
  logic [63:0] arena_lo, arena_hi;
  logic [31:0] frag_off [NSLOT];
  logic [31:0] frag_len [NSLOT];
  logic        frag_alive [NSLOT];
  int unsigned head_q, tail_q, used_q, alive_q, size_log2;

  outcome_t    expected_outcomes [$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  longint      cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic void queue_expected(input outcome_t o);
    expected_outcomes.insert(expected_outcomes.size(), o);
  endfunction

  function automatic outcome_t take_expected();
    outcome_t o;
    o = expected_outcomes[0];
    expected_outcomes.delete(0);
    return o;
  endfunction

  function automatic int unsigned used_log2();
    int unsigned l;
    l = size_log2;
    if (l < 4) l = 4;
    if (l > 32) l = 32;
    return l;
  endfunction

  function automatic void empty_arena();
    arena_lo = 0;
    arena_hi = 64'd1 << used_log2();
    head_q = 0;
    tail_q = 0;
    used_q = 0;
    alive_q = 0;
    for (int i = 0; i < NSLOT; i++) frag_alive[i] = 1'b0;
  endfunction

  function automatic int unsigned nxt(int unsigned i);
    return (i + 1 >= NSLOT) ? 0 : i + 1;
  endfunction

  function automatic int unsigned prv(int unsigned i);
    return (i == 0) ? NSLOT - 1 : i - 1;
  endfunction

  function automatic outcome_t predict_outcome(cmd_t cmd, logic [31:0] req32,
                                               logic [4:0] align, logic [3:0] hnd);
    outcome_t    r;
    int unsigned l, h, p;
    logic [63:0] span, msk, req, am, ab, ae, alb, ale, fin;
    bit          front, back;
    r = '{ST_DONE, 4'd0, 32'd0};
    l = used_log2();
    span = 64'd1 << l;
    msk = span - 1;
    if (cmd == CMD_ALLOC) begin
      req = {32'd0, req32};
      if (used_q >= NSLOT) begin
        r.status = ST_FULL;
      end else if (req == 0) begin
        r.status = ST_NO_SPACE;
      end else begin
        am = (64'd1 << align) - 1;
        ab = arena_lo & msk;
        ae = arena_hi & msk;
        alb = (ab + am) & ~am;
        ale = ae & ~am;
        front = 0;
        back = 0;
        if ((arena_lo >> l) == (arena_hi >> l)) front = (alb + req <= ae);
        else if (alb + req <= span) front = 1;
        else if (req <= ale) back = 1;
        if (front) begin
          arena_lo += (alb - ab) + req;
          r.offset = alb[31:0];
          r.slot = tail_q[3:0];
          tail_q = nxt(tail_q);
        end else if (back) begin
          arena_hi -= (ae - ale) + req;
          r.offset = ale[31:0] - req32;
          head_q = prv(head_q);
          r.slot = head_q[3:0];
        end else begin
          r.status = ST_NO_SPACE;
        end
        if (front || back) begin
          frag_off[r.slot] = r.offset;
          frag_len[r.slot] = req32;
          frag_alive[r.slot] = 1'b1;
          used_q++;
          alive_q++;
        end
      end
    end else begin
      h = hnd;
      if (!frag_alive[h]) begin
        r.status = ST_BAD;
      end else if (alive_q <= 1) begin
        empty_arena();
      end else begin
        frag_alive[h] = 1'b0;
        alive_q--;
        if (h == head_q) begin
          while (!frag_alive[head_q]) begin
            head_q = nxt(head_q);
            used_q--;
          end
          arena_hi += ({32'd0, frag_off[head_q]} - arena_hi) & msk;
        end else if (h == prv(tail_q)) begin
          while (!frag_alive[prv(tail_q)]) begin
            tail_q = prv(tail_q);
            used_q--;
          end
          p = prv(tail_q);
          fin = {32'd0, frag_off[p]} + {32'd0, frag_len[p]};
          arena_lo -= (arena_lo - fin) & msk;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_command(input cmd_t cmd, input logic [31:0] req,
                              input logic [4:0] align, input logic [3:0] hnd);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    queue_expected(predict_outcome(cmd, req, align, hnd));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, hnd, align, req, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic alloc(input logic [31:0] req, input logic [4:0] align);
    send_command(CMD_ALLOC, req, align, 4'd0);
  endtask

  task automatic release_slot(input logic [3:0] hnd);
    send_command(CMD_FREE, 32'd0, 5'd0, hnd);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_arena_log2(input logic [5:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_log2 = v;
    empty_arena();
  endtask

  // Receiver side: random stalls and checking.
  always @(posedge clk) begin
    outcome_t got, want;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[37:6]};
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", {26'd0, m_axis_tdata[5:0]}, 32'd0);
      end else begin
        want = take_expected();
        if (got.status !== want.status)
          report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
        if (got.slot !== want.slot)
          report_mismatch("slot", {28'd0, got.slot}, {28'd0, want.slot});
        if (got.offset !== want.offset) report_mismatch("offset", got.offset, want.offset);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    wait (cycles > 3000000);
    $display("** double_ended_ring_allocator: FAILED **");
    $finish;
  end

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      if ($urandom_range(9) == 0) alloc($urandom, 5'($urandom_range(31)));
      else alloc(32'($urandom_range(1, 32'd1 << $urandom_range(used_log2() - 1))),
                 5'($urandom_range(6)));
    end else if (pick < 95) begin
      release_slot(4'($urandom_range(15)));
    end else begin
      alloc($urandom_range(3) == 0 ? 32'd0 : $urandom, 5'($urandom));
    end
  endtask

  task automatic test_directed();
    alloc(32'd0, 5'd0);
    alloc(32'hFFFF_FFFF, 5'd31);
    release_slot(4'd15);
    alloc(32'd100, 5'd4);
    alloc(32'd1, 5'd0);
    alloc(32'd4096, 5'd12);
    release_slot(4'd1);
    alloc(32'd2, 5'd31);
    release_slot(4'd0);
    release_slot(4'd2);
    release_slot(4'd2);
    write_arena_log2(6'd4);
    for (int i = 0; i < 17; i++) alloc(32'd1, 5'd0);
    release_slot(4'd5);
    release_slot(4'd0);
    release_slot(4'd15);
    alloc(32'd1, 5'd0);
  endtask

  task automatic test_ring_wrap(input int n);
    repeat (n) random_item();
  endtask

  task automatic test_extremes();
    write_arena_log2(6'd0);
    repeat (40) random_item();
    write_arena_log2(6'd63);
    alloc(32'hFFFF_FFFF, 5'd0);
    alloc(32'd1, 5'd31);
    repeat (40) random_item();
    write_arena_log2(6'd32);
    repeat (40) random_item();
  endtask

  initial begin
    size_log2 = LOG2_RESET;
    empty_arena();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 20;
    recv_idle = 66;
    test_directed();
    write_arena_log2(6'd8);
    test_ring_wrap(250);
    send_idle = 66;
    recv_idle = 20;
    write_arena_log2(6'd5);
    test_ring_wrap(220);
    test_extremes();
    send_idle = 0;
    recv_idle = 0;
    write_arena_log2(6'd12);
    test_ring_wrap(230);
    drain();
    if (errors == 0 && expected_outcomes.size() == 0)
      $display("** double_ended_ring_allocator: PASSED **");
    else
      $display("** double_ended_ring_allocator: FAILED **");
    $finish;
  end
endmodule

@@ double_ended_ring_allocator.f @@
design/dera_pkg.sv
design/dera_ram.sv
design/double_ended_ring_allocator.sv
tb/double_ended_ring_allocator_tb.sv
